### src/wald_pkg.sv
// ----------------------------------------------------------------------------
// wald_pkg
// Shared constants, types and state encoding of the waypoint decimator.
// ----------------------------------------------------------------------------
`default_nettype none

package wald_pkg;

    localparam int FRAC_BITS    = 8;
    localparam int ACC_WIDTH    = 40;
    localparam int TILE_METRES  = 100;
    localparam int TILE_DIVISOR = 2;

    localparam int COORD_W = 32;
    localparam int TRIG_W  = 24;
    localparam int ROOT_W  = COORD_W;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 2;
    localparam int CNT_W   = $clog2(ROOT_W);

    localparam logic [TRIG_W-1:0] TRIGGER_RESET =
        TRIG_W'((TILE_METRES / TILE_DIVISOR) << FRAC_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SUM,
        ST_ROOT,
        ST_ACC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] emit_x;
        logic signed [COORD_W-1:0] emit_y;
        logic                      flush_before;
        logic                      by_distance;
    } t_res;

    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] radicand;
    } t_root_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_root_rsp;

endpackage

`default_nettype wire

### src/wald_if.sv
// ----------------------------------------------------------------------------
// wald_if
// Valid/ready channel interfaces: waypoint input, emitted point, config write.
// ----------------------------------------------------------------------------
`default_nettype none

interface wald_pt_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [wald_pkg::COORD_W-1:0]       point_x;
    logic signed [wald_pkg::COORD_W-1:0]       point_y;
    logic                                      lane_first;
    logic                                      lane_last;
    logic                                      route_start;

    modport source (output valid, point_x, point_y, lane_first, lane_last, route_start,
                    input ready);
    modport sink   (input valid, point_x, point_y, lane_first, lane_last, route_start,
                    output ready);
endinterface

interface wald_em_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [wald_pkg::COORD_W-1:0]       emit_x;
    logic signed [wald_pkg::COORD_W-1:0]       emit_y;
    logic                                      flush_before;
    logic                                      by_distance;

    modport source (output valid, emit_x, emit_y, flush_before, by_distance,
                    input ready);
    modport sink   (input valid, emit_x, emit_y, flush_before, by_distance,
                    output ready);
endinterface

interface wald_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [wald_pkg::TRIG_W-1:0]        data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### src/wald_isqrt.sv
// ----------------------------------------------------------------------------
// wald_isqrt
// Integer square root by digit recurrence, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wald_isqrt (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire wald_pkg::t_root_req   i_req,
    output wald_pkg::t_root_rsp        o_rsp
);

    localparam logic [wald_pkg::CNT_W-1:0] LAST_CNT = wald_pkg::CNT_W'(wald_pkg::ROOT_W - 1);

    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    logic [wald_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [wald_pkg::RAD_W-1:0]      r_rad, n_rad;
    logic [wald_pkg::REM_W-1:0]      r_rem, n_rem;
    logic [wald_pkg::ROOT_W-1:0]     r_root, n_root;

    logic [wald_pkg::REM_W+1:0]      rem_sh;
    logic [wald_pkg::REM_W+1:0]      trial;
    logic                            ge;

    always_comb begin
        rem_sh = {r_rem, r_rad[wald_pkg::RAD_W-1 -: 2]};
        trial  = (wald_pkg::REM_W+2)'({r_root, 2'b01});
        ge     = (rem_sh >= trial);

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;

        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rad  = i_req.radicand;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            // bring down the next bit pair, try root*4+1
            n_rad  = {r_rad[wald_pkg::RAD_W-3:0], 2'b00};
            n_rem  = ge ? wald_pkg::REM_W'(rem_sh - trial) : wald_pkg::REM_W'(rem_sh);
            n_root = {r_root[wald_pkg::ROOT_W-2:0], ge};
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == LAST_CNT) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

endmodule

`default_nettype wire

### src/wald_core.sv
// ----------------------------------------------------------------------------
// wald_core
// Sequencer: step length via shared multiplier and root unit, running distance.
// ----------------------------------------------------------------------------
`default_nettype none

module wald_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    wald_pt_if.sink                            i_pt,
    input  wire logic [wald_pkg::TRIG_W-1:0]   i_trigger,
    output wald_pkg::t_res                     o_res,
    output logic                               o_res_valid,
    input  wire logic                          i_res_free,
    output wald_pkg::t_root_req                o_root_req,
    input  wire wald_pkg::t_root_rsp           i_root_rsp
);

    localparam logic [wald_pkg::ACC_WIDTH-1:0] ACC_MAX = '1;

    wald_pkg::t_state                     r_state, n_state;
    logic [wald_pkg::COORD_W-1:0]         r_prev_x, n_prev_x;
    logic [wald_pkg::COORD_W-1:0]         r_prev_y, n_prev_y;
    logic [wald_pkg::ACC_WIDTH-1:0]       r_acc, n_acc;
    logic [wald_pkg::COORD_W-1:0]         r_mag_x, n_mag_x;
    logic [wald_pkg::COORD_W-1:0]         r_mag_y, n_mag_y;
    logic [wald_pkg::RAD_W-1:0]           r_sq_x, n_sq_x;
    logic [wald_pkg::RAD_W-1:0]           r_sq_y, n_sq_y;
    wald_pkg::t_res                       r_res, n_res;

    logic        accept;
    logic        endpoint;
    logic [wald_pkg::COORD_W:0]           dx, dy;
    logic [wald_pkg::COORD_W:0]           adx, ady;
    logic [wald_pkg::COORD_W-1:0]         mul_a;
    logic [wald_pkg::RAD_W-1:0]           prod;
    logic [wald_pkg::RAD_W:0]             rad_sum;
    logic [wald_pkg::ACC_WIDTH:0]         acc_sum;

    always_comb begin
        accept   = i_pt.valid && (r_state == wald_pkg::ST_IDLE);
        endpoint = i_pt.lane_first || i_pt.lane_last || i_pt.route_start;

        dx  = {i_pt.point_x[wald_pkg::COORD_W-1], i_pt.point_x}
            - {r_prev_x[wald_pkg::COORD_W-1], r_prev_x};
        dy  = {i_pt.point_y[wald_pkg::COORD_W-1], i_pt.point_y}
            - {r_prev_y[wald_pkg::COORD_W-1], r_prev_y};
        adx = dx[wald_pkg::COORD_W] ? -dx : dx;
        ady = dy[wald_pkg::COORD_W] ? -dy : dy;

        // one multiplier, squares x then y
        mul_a = (r_state == wald_pkg::ST_SQX) ? r_mag_x : r_mag_y;
        prod  = mul_a * mul_a;

        rad_sum = {1'b0, r_sq_x} + {1'b0, r_sq_y};
        acc_sum = {1'b0, r_acc} + (wald_pkg::ACC_WIDTH+1)'(i_root_rsp.root);

        n_state  = r_state;
        n_prev_x = r_prev_x;
        n_prev_y = r_prev_y;
        n_acc    = r_acc;
        n_mag_x  = r_mag_x;
        n_mag_y  = r_mag_y;
        n_sq_x   = r_sq_x;
        n_sq_y   = r_sq_y;
        n_res    = r_res;

        o_root_req.start    = 1'b0;
        o_root_req.radicand = rad_sum[wald_pkg::RAD_W] ? '1 : rad_sum[wald_pkg::RAD_W-1:0];
        o_res_valid         = 1'b0;
        i_pt.ready          = (r_state == wald_pkg::ST_IDLE);

        unique case (r_state)
            wald_pkg::ST_IDLE: begin
                if (accept) begin
                    n_prev_x           = i_pt.point_x;
                    n_prev_y           = i_pt.point_y;
                    n_res.emit_x       = i_pt.point_x;
                    n_res.emit_y       = i_pt.point_y;
                    n_res.flush_before = i_pt.route_start;
                    n_res.by_distance  = !endpoint;
                    n_mag_x            = adx[wald_pkg::COORD_W-1:0];
                    n_mag_y            = ady[wald_pkg::COORD_W-1:0];
                    if (endpoint) begin
                        if (i_pt.lane_first || i_pt.route_start) begin
                            n_acc = '0;
                        end
                        n_state = wald_pkg::ST_DONE;
                    end else begin
                        n_state = wald_pkg::ST_SQX;
                    end
                end
            end
            wald_pkg::ST_SQX: begin
                n_sq_x  = prod;
                n_state = wald_pkg::ST_SQY;
            end
            wald_pkg::ST_SQY: begin
                n_sq_y  = prod;
                n_state = wald_pkg::ST_SUM;
            end
            wald_pkg::ST_SUM: begin
                o_root_req.start = 1'b1;
                n_state          = wald_pkg::ST_ROOT;
            end
            wald_pkg::ST_ROOT: begin
                if (i_root_rsp.done) begin
                    n_acc   = acc_sum[wald_pkg::ACC_WIDTH] ? ACC_MAX
                                                           : acc_sum[wald_pkg::ACC_WIDTH-1:0];
                    n_state = wald_pkg::ST_ACC;
                end
            end
            wald_pkg::ST_ACC: begin
                if (r_acc > wald_pkg::ACC_WIDTH'(i_trigger)) begin
                    n_acc   = '0;
                    n_state = wald_pkg::ST_DONE;
                end else begin
                    n_state = wald_pkg::ST_IDLE;
                end
            end
            wald_pkg::ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_free) begin
                    n_state = wald_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wald_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= wald_pkg::ST_IDLE;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_acc    <= '0;
        end else begin
            r_state  <= n_state;
            r_prev_x <= n_prev_x;
            r_prev_y <= n_prev_y;
            r_acc    <= n_acc;
        end
        r_mag_x <= n_mag_x;
        r_mag_y <= n_mag_y;
        r_sq_x  <= n_sq_x;
        r_sq_y  <= n_sq_y;
        r_res   <= n_res;
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

### src/waypoint_arc_length_decimator.sv
// ----------------------------------------------------------------------------
// waypoint_arc_length_decimator
// Emits lane endpoints and inner waypoints spaced by accumulated arc length.
//
//   channel  dir  payload                                        transfer when
//   i_pt     in   point_x, point_y, lane_first, lane_last,       valid & ready
//                 route_start
//   o_em     out  emit_x, emit_y, flush_before, by_distance      valid & ready
//   i_cfg    in   data = trigger_distance (24 bit)               valid & ready
//
// Endpoint waypoints pass from accept through the done state to the output
// register. Inner waypoints hold the input through accept, two squares on one
// multiplier, a sum, 32 iterations of the root unit, accumulate and compare;
// an emitted one passes the done state too. Input is not ready while an item
// is in work; a result stalled on o_em holds the sequencer in its last state.
// Reset sets trigger_distance to 12800 and clears previous point and distance.
// ----------------------------------------------------------------------------
`default_nettype none

module waypoint_arc_length_decimator (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    wald_pt_if.sink        i_pt,
    wald_em_if.source      o_em,
    wald_cfg_if.sink       i_cfg
);

    logic [wald_pkg::TRIG_W-1:0] r_trigger;
    logic                        r_out_valid, n_out_valid;
    wald_pkg::t_res              r_out, n_out;

    wald_pkg::t_res              core_res;
    logic                        core_res_valid;
    logic                        res_free;
    wald_pkg::t_root_req         root_req;
    wald_pkg::t_root_rsp         root_rsp;

    assign i_cfg.ready = 1'b1;
    assign res_free    = !r_out_valid || o_em.ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (o_em.ready) begin
            n_out_valid = 1'b0;
        end
        if (core_res_valid && res_free) begin
            n_out_valid = 1'b1;
            n_out       = core_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger   <= wald_pkg::TRIGGER_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_trigger <= i_cfg.data;
            end
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    wald_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pt        (i_pt),
        .i_trigger   (r_trigger),
        .o_res       (core_res),
        .o_res_valid (core_res_valid),
        .i_res_free  (res_free),
        .o_root_req  (root_req),
        .i_root_rsp  (root_rsp)
    );

    wald_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (root_req),
        .o_rsp   (root_rsp)
    );

    assign o_em.valid        = r_out_valid;
    assign o_em.emit_x       = r_out.emit_x;
    assign o_em.emit_y       = r_out.emit_y;
    assign o_em.flush_before = r_out.flush_before;
    assign o_em.by_distance  = r_out.by_distance;

endmodule

`default_nettype wire
